// ----- hw/rtl/lsls_pkg.sv -----
package lsls_pkg;

  // Width of the blink, silence and pulse down-counters
  localparam int unsigned TIMER_BITS = 16;
  // Width of every configuration register
  localparam int unsigned CFG_W = 16;
  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 8;

  // Largest counter value, kept wide enough for any counter width up to 32
  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BLINK_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_BLINK_IDX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN_IDX  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_IDX    = CFG_IDX_W'(3);

  // Configuration reset values
  localparam logic [CFG_W-1:0] SLOW_BLINK_RST = CFG_W'(2000);
  localparam logic [CFG_W-1:0] FAST_BLINK_RST = CFG_W'(160);
  localparam logic [CFG_W-1:0] PULSE_LEN_RST  = CFG_W'(80);
  localparam logic [CFG_W-1:0] SILENCE_RST    = CFG_W'(500);

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_LINK    = 2'd1,
    MODE_FLASH   = 2'd2,
    MODE_PAIRING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_LINK     = 2'd1,
    OP_ACTIVITY = 2'd2,
    OP_PAIRING  = 2'd3
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0] slow_blink_period;
    logic [CFG_W-1:0] fast_blink_period;
    logic [CFG_W-1:0] pulse_length;
    logic [CFG_W-1:0] silence_timeout;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  lit;
    logic                  pairing;
    logic [TIMER_BITS-1:0] blink_cnt;
    logic [TIMER_BITS-1:0] silence_cnt;
    logic [TIMER_BITS-1:0] pulse_cnt;
  } state_t;

  // Turn a tick count into a counter load: zero becomes one, too large saturates
  function automatic logic [TIMER_BITS-1:0] arm_value(logic [CFG_W-1:0] ticks);
    logic [TIMER_BITS-1:0] r;
    if (ticks == '0) begin
      r = TIMER_BITS'(1);
    end else if (33'(ticks) > TIMER_MAX) begin
      r = TIMER_BITS'(TIMER_MAX);
    end else begin
      r = TIMER_BITS'(ticks);
    end
    return r;
  endfunction

  // Full blink period of a mode, zero for modes that do not blink
  function automatic logic [CFG_W-1:0] mode_period(mode_t m, cfg_t c);
    logic [CFG_W-1:0] r;
    case (m)
      MODE_PAIRING: r = c.fast_blink_period;
      MODE_LINK:    r = c.slow_blink_period;
      default:      r = '0;
    endcase
    return r;
  endfunction

  // Enter a mode: set the LED and load or disarm the blink counter
  function automatic state_t enter_mode(state_t s, mode_t m, cfg_t c);
    state_t           r;
    logic [CFG_W-1:0] period;
    r = s;
    r.mode = m;
    r.blink_cnt = '0;
    period = mode_period(m, c);
    if (m == MODE_FLASH) begin
      r.lit = 1'b1;
    end else if (period == '0) begin
      r.lit = 1'b0;
    end else begin
      r.lit = 1'b1;
      r.blink_cnt = arm_value({1'b0, period[CFG_W-1:1]});
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/link_status_led_sequencer.sv -----
// Link status LED sequencer.
// Input channel (in_valid/in_ready) carries one event per transaction:
// in_operation 0 millisecond tick, 1 link keepalive, 2 activity, 3 set pairing
// (in_pairing gives the new flag). Each accepted transaction yields exactly one
// result transaction on out_valid/out_ready: the LED level and the mode after
// that event.
// The event is applied to the state registers and the result register at the
// accepting edge, and out_valid is high the next cycle.
// Throughput is one transaction per cycle while the receiver takes each result;
// the single update path between the state registers and the result register sets that figure.
// When the receiver stalls, the result register holds and in_ready drops until
// the result is taken; a new event is accepted in the same cycle the held
// result leaves.
// Reset (rst_n low, synchronous) puts the LED dark in off mode with all timers
// disarmed, and loads the register defaults 2000, 160, 80 and 500 ticks.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the edge;
// indexes above three are ignored.
module link_status_led_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_operation,
  input  logic                           in_pairing,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_led_level,
  output logic [1:0]                     out_current_mode,
  input  logic                           cfg_we,
  input  logic [lsls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsls_pkg::CFG_W-1:0]     cfg_wdata
);

  lsls_pkg::cfg_t   cfg_r;
  lsls_pkg::state_t state_r;
  lsls_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_lit_r;
  lsls_pkg::mode_t  out_mode_r;
  logic             in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_blink_period <= lsls_pkg::SLOW_BLINK_RST;
      cfg_r.fast_blink_period <= lsls_pkg::FAST_BLINK_RST;
      cfg_r.pulse_length      <= lsls_pkg::PULSE_LEN_RST;
      cfg_r.silence_timeout   <= lsls_pkg::SILENCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lsls_pkg::CFG_SLOW_BLINK_IDX: cfg_r.slow_blink_period <= cfg_wdata;
        lsls_pkg::CFG_FAST_BLINK_IDX: cfg_r.fast_blink_period <= cfg_wdata;
        lsls_pkg::CFG_PULSE_LEN_IDX:  cfg_r.pulse_length      <= cfg_wdata;
        lsls_pkg::CFG_SILENCE_IDX:    cfg_r.silence_timeout   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lsls_update u_update (
    .cur       (state_r),
    .cfg       (cfg_r),
    .operation (lsls_pkg::op_t'(in_operation)),
    .pairing   (in_pairing),
    .nxt       (state_nxt)
  );

  // Advance the sequencer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= lsls_pkg::MODE_OFF;
      state_r.lit         <= 1'b0;
      state_r.pairing     <= 1'b0;
      state_r.blink_cnt   <= '0;
      state_r.silence_cnt <= '0;
      state_r.pulse_cnt   <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_lit_r  <= state_nxt.lit;
      out_mode_r <= state_nxt.mode;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_level    = out_lit_r;
  assign out_current_mode = out_mode_r;

endmodule

// ----- hw/rtl/lsls_update.sv -----
module lsls_update (
  input  lsls_pkg::state_t cur,
  input  lsls_pkg::cfg_t   cfg,
  input  lsls_pkg::op_t    operation,
  input  logic             pairing,
  output lsls_pkg::state_t nxt
);

  logic                            blink_fired;
  logic                            silence_fired;
  logic                            pulse_fired;
  logic [lsls_pkg::CFG_W-1:0]      period;
  lsls_pkg::state_t                s;

  // Apply one event to the sequencer state
  always_comb begin
    s = cur;
    blink_fired = 1'b0;
    silence_fired = 1'b0;
    pulse_fired = 1'b0;
    period = '0;
    case (operation)
      lsls_pkg::OP_TICK: begin
        // Count down armed counters; an armed counter expires going to zero
        blink_fired   = (cur.blink_cnt == lsls_pkg::TIMER_BITS'(1));
        silence_fired = (cur.silence_cnt == lsls_pkg::TIMER_BITS'(1));
        pulse_fired   = (cur.pulse_cnt == lsls_pkg::TIMER_BITS'(1));
        if (cur.blink_cnt != '0) s.blink_cnt = cur.blink_cnt - lsls_pkg::TIMER_BITS'(1);
        if (cur.silence_cnt != '0) begin
          s.silence_cnt = cur.silence_cnt - lsls_pkg::TIMER_BITS'(1);
        end
        if (cur.pulse_cnt != '0) s.pulse_cnt = cur.pulse_cnt - lsls_pkg::TIMER_BITS'(1);
        // Blink expiry: toggle and reload with half the period, or go dark if the mode does not blink
        if (blink_fired) begin
          period = lsls_pkg::mode_period(s.mode, cfg);
          if (period == '0) begin
            s.lit = 1'b0;
          end else begin
            s.lit = ~s.lit;
            s.blink_cnt = lsls_pkg::arm_value({1'b0, period[lsls_pkg::CFG_W-1:1]});
          end
        end
        // Silence expiry: drop the pulse and go dark
        if (silence_fired && !s.pairing) begin
          s.pulse_cnt = '0;
          pulse_fired = 1'b0;
          s = lsls_pkg::enter_mode(s, lsls_pkg::MODE_OFF, cfg);
        end
        // Pulse expiry: return from flash to link
        if (pulse_fired && !s.pairing && s.mode == lsls_pkg::MODE_FLASH) begin
          s = lsls_pkg::enter_mode(s, lsls_pkg::MODE_LINK, cfg);
        end
      end
      lsls_pkg::OP_LINK: begin
        if (!cur.pairing) begin
          s.silence_cnt = lsls_pkg::arm_value(cfg.silence_timeout);
          if (cur.mode == lsls_pkg::MODE_OFF) begin
            s = lsls_pkg::enter_mode(s, lsls_pkg::MODE_LINK, cfg);
          end
        end
      end
      lsls_pkg::OP_ACTIVITY: begin
        if (!cur.pairing) begin
          s.silence_cnt = lsls_pkg::arm_value(cfg.silence_timeout);
          s = lsls_pkg::enter_mode(s, lsls_pkg::MODE_FLASH, cfg);
          s.pulse_cnt = lsls_pkg::arm_value(cfg.pulse_length);
        end
      end
      default: begin
        // Set or clear pairing; all timers but blink are disarmed
        s.pairing = pairing;
        s.silence_cnt = '0;
        s.pulse_cnt = '0;
        s = lsls_pkg::enter_mode(s, pairing ? lsls_pkg::MODE_PAIRING : lsls_pkg::MODE_OFF,
                                 cfg);
      end
    endcase
    nxt = s;
  end

endmodule

// ----- tb/led_sequence_checker.sv -----
module led_sequence_checker
  import lsls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic                 in_pairing,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_led_level,
  input  logic [1:0]           out_current_mode,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic  lit;
    mode_t mode;
  } led_view_t;

  // Register copy and predicted sequencer state
  cfg_t                  regs;
  mode_t                 led_mode;
  logic                  led_on;
  logic                  pair_on;
  logic [TIMER_BITS-1:0] blink_left;
  logic [TIMER_BITS-1:0] silence_left;
  logic [TIMER_BITS-1:0] pulse_left;

  led_view_t expected_leds[$];
  int        mismatch_total = 0;
  int        result_idx = 0;

  // Zero becomes one, anything past the counter width saturates
  function automatic logic [TIMER_BITS-1:0] ticks_to_load(logic [CFG_W-1:0] ticks);
    logic [32:0] wide;
    wide = 33'(ticks);
    if (wide == 33'd0) begin
      wide = 33'd1;
    end
    if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return TIMER_BITS'(wide);
  endfunction

  function automatic logic [CFG_W-1:0] blink_period_of(mode_t m);
    logic [CFG_W-1:0] p;
    case (m)
      MODE_LINK:    p = regs.slow_blink_period;
      MODE_PAIRING: p = regs.fast_blink_period;
      default:      p = '0;
    endcase
    return p;
  endfunction

  // Set the LED for a new mode and load or disarm the blink timer
  task automatic switch_mode(mode_t m);
    logic [CFG_W-1:0] period;
    led_mode = m;
    blink_left = '0;
    period = blink_period_of(m);
    if (m == MODE_FLASH) begin
      led_on = 1'b1;
    end else if (period == '0) begin
      led_on = 1'b0;
    end else begin
      led_on = 1'b1;
      blink_left = ticks_to_load(period >> 1);
    end
  endtask

  // Count all timers down, then handle expiries as blink, silence, pulse
  task automatic run_tick();
    logic             blink_hit;
    logic             silence_hit;
    logic             pulse_hit;
    logic [CFG_W-1:0] period;
    blink_hit   = (blink_left == TIMER_BITS'(1));
    silence_hit = (silence_left == TIMER_BITS'(1));
    pulse_hit   = (pulse_left == TIMER_BITS'(1));
    if (blink_left != '0) begin
      blink_left = blink_left - 1'b1;
    end
    if (silence_left != '0) begin
      silence_left = silence_left - 1'b1;
    end
    if (pulse_left != '0) begin
      pulse_left = pulse_left - 1'b1;
    end
    if (blink_hit) begin
      period = blink_period_of(led_mode);
      if (period == '0) begin
        led_on = 1'b0;
      end else begin
        led_on = ~led_on;
        blink_left = ticks_to_load(period >> 1);
      end
    end
    // Silence wins over a pulse ending on the same tick
    if (silence_hit && !pair_on) begin
      pulse_left = '0;
      pulse_hit = 1'b0;
      switch_mode(MODE_OFF);
    end
    if (pulse_hit && !pair_on && led_mode == MODE_FLASH) begin
      switch_mode(MODE_LINK);
    end
  endtask

  task automatic apply_event(op_t op, logic pair);
    case (op)
      OP_TICK: begin
        run_tick();
      end
      OP_LINK: begin
        if (!pair_on) begin
          silence_left = ticks_to_load(regs.silence_timeout);
          if (led_mode == MODE_OFF) begin
            switch_mode(MODE_LINK);
          end
        end
      end
      OP_ACTIVITY: begin
        if (!pair_on) begin
          silence_left = ticks_to_load(regs.silence_timeout);
          switch_mode(MODE_FLASH);
          pulse_left = ticks_to_load(regs.pulse_length);
        end
      end
      OP_PAIRING: begin
        pair_on = pair;
        silence_left = '0;
        pulse_left = '0;
        switch_mode(pair ? MODE_PAIRING : MODE_OFF);
      end
      default: ;
    endcase
  endtask

  task automatic flag_result(string what);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%t led result %0d: %s", $realtime, result_idx, what);
    end
  endtask

  always @(posedge clk) begin
    led_view_t exp_led;
    if (!rst_n) begin
      regs.slow_blink_period = SLOW_BLINK_RST;
      regs.fast_blink_period = FAST_BLINK_RST;
      regs.pulse_length      = PULSE_LEN_RST;
      regs.silence_timeout   = SILENCE_RST;
      led_mode     = MODE_OFF;
      led_on       = 1'b0;
      pair_on      = 1'b0;
      blink_left   = '0;
      silence_left = '0;
      pulse_left   = '0;
      expected_leds.delete();
    end else begin
      // Compare the outgoing transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          flag_result($sformatf("got level %0b mode %0d with nothing outstanding",
                                out_led_level, out_current_mode));
        end else begin
          exp_led = expected_leds.pop_front();
          if (out_led_level !== exp_led.lit || out_current_mode !== exp_led.mode) begin
            flag_result($sformatf("expected level %0b mode %0d, got level %0b mode %0d",
                                  exp_led.lit, exp_led.mode, out_led_level,
                                  out_current_mode));
          end
        end
        result_idx++;
      end
      // Predict the result of an incoming transaction
      if (in_valid && in_ready) begin
        apply_event(op_t'(in_operation), in_pairing);
        exp_led.lit  = led_on;
        exp_led.mode = led_mode;
        expected_leds.push_back(exp_led);
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOW_BLINK_IDX: regs.slow_blink_period = cfg_wdata;
          CFG_FAST_BLINK_IDX: regs.fast_blink_period = cfg_wdata;
          CFG_PULSE_LEN_IDX:  regs.pulse_length      = cfg_wdata;
          CFG_SILENCE_IDX:    regs.silence_timeout   = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_leds.size();
    fail_count = mismatch_total;
  end

endmodule

// ----- tb/link_status_led_sequencer_tb.sv -----
module link_status_led_sequencer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lsls_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  bit                   clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_operation;
  logic                 in_pairing;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_led_level;
  logic [1:0]           out_current_mode;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;

  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_status_led_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_pairing       (in_pairing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_level    (out_led_level),
    .out_current_mode (out_current_mode),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  led_sequence_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_pairing       (in_pairing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_level    (out_led_level),
    .out_current_mode (out_current_mode),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Mostly short gaps, a few long ones, none during busy stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Offer one event and hold it until the transaction completes
  task automatic send_event(input op_t op, input logic pair);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pairing   <= pair;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly ticks so the timers run out, with keepalive, activity and pairing mixed in
  task automatic send_random_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_event(OP_TICK, 1'($urandom_range(0, 1)));
    end else if (r < 75) begin
      send_event(OP_LINK, 1'($urandom_range(0, 1)));
    end else if (r < 88) begin
      send_event(OP_ACTIVITY, 1'($urandom_range(0, 1)));
    end else begin
      send_event(OP_PAIRING, 1'($urandom_range(0, 2) == 0));
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all four registers plus one index the block ignores
  task automatic program_regs(input logic [CFG_W-1:0] slow, input logic [CFG_W-1:0] fast,
                              input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] silence);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLOW_BLINK_IDX;
    cfg_wdata <= slow;
    @(negedge clk);
    cfg_index <= CFG_FAST_BLINK_IDX;
    cfg_wdata <= fast;
    @(negedge clk);
    cfg_index <= CFG_PULSE_LEN_IDX;
    cfg_wdata <= pulse;
    @(negedge clk);
    cfg_index <= CFG_SILENCE_IDX;
    cfg_wdata <= silence;
    @(negedge clk);
    cfg_index <= CFG_IDX_W'(CFG_SILENCE_IDX + 1 + $urandom_range(0, 251));
    cfg_wdata <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_TICK;
    in_pairing   = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SLOW_BLINK_IDX;
    cfg_wdata    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero slow period, period of one, zero pulse length
    program_regs(16'd0, 16'd1, 16'd0, 16'd3);
    send_event(OP_TICK, 1'b0);
    send_event(OP_LINK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_ACTIVITY, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PAIRING, 1'b1);
    send_event(OP_TICK, 1'b1);
    send_event(OP_TICK, 1'b0);
    send_event(OP_LINK, 1'b1);
    send_event(OP_ACTIVITY, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PAIRING, 1'b0);

    // Silence and pulse ending on one tick, zero fast period while pairing
    program_regs(16'd2, 16'd0, 16'd3, 16'd3);
    send_event(OP_ACTIVITY, 1'b1);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_LINK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PAIRING, 1'b1);
    send_event(OP_TICK, 1'b0);
    send_event(OP_PAIRING, 1'b0);

    // Random phases over several register settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: program_regs(CFG_W'($urandom_range(2, 12)), CFG_W'($urandom_range(2, 8)),
                        CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 20)));
        1: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_regs(16'd2, 16'd2, 16'd1, 16'd1);
        4: program_regs(SLOW_BLINK_RST, FAST_BLINK_RST, PULSE_LEN_RST, SILENCE_RST);
        5: program_regs(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)),
                        CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)));
        6: program_regs(16'd1, 16'd3, 16'hFFFF, 16'd40);
        default: program_regs(CFG_W'($urandom_range(2, 16)), CFG_W'($urandom_range(2, 10)),
                              CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(4, 30)));
      endcase
      no_idle = (phase % 3 == 2);
      // Stall the receiver for a long stretch while events keep coming
      if (phase == 3) begin
        hold_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_random_event();
    end

    wait_idle();
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lsls_pkg.sv
hw/rtl/lsls_update.sv
hw/rtl/link_status_led_sequencer.sv
tb/led_sequence_checker.sv
tb/link_status_led_sequencer_tb.sv
